// ===== sv/splat_pkg.sv =====
// Shared types and constants for the stream packet latency statistics block.
package splat_pkg;

   localparam int unsigned CMD_W   = 3;
   localparam int unsigned BYTES_W = 16;
   localparam int unsigned LAT_W   = 32;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned BCNT_W  = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_SENT     = 3'd0,
      CMD_RECV     = 3'd1,
      CMD_SEQ_ERR  = 3'd2,
      CMD_TS_ERR   = 3'd3,
      CMD_CLEAR    = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  sent_packets;
      logic [CNT_W-1:0]  recv_packets;
      logic [BCNT_W-1:0] sent_bytes;
      logic [BCNT_W-1:0] recv_bytes;
      logic [CNT_W-1:0]  seq_errors;
      logic [CNT_W-1:0]  ts_errors;
      logic [LAT_W-1:0]  max_latency;
      logic [LAT_W-1:0]  min_latency;
      logic [LAT_W-1:0]  avg_latency;
   } stats_type;

   localparam stats_type STATS_RESET = '{
      sent_packets: '0,
      recv_packets: '0,
      sent_bytes:   '0,
      recv_bytes:   '0,
      seq_errors:   '0,
      ts_errors:    '0,
      max_latency:  '0,
      min_latency:  '1,
      avg_latency:  '0
   };

endpackage

// ===== sv/splat_update.sv =====
// Next-state logic of the statistics counters for one event.
module splat_update
   import splat_pkg::*;
(
   input  stats_type          cur,
   input  cmd_type            cmd,
   input  logic [BYTES_W-1:0] pkt_bytes,
   input  logic [LAT_W-1:0]   latency,
   output stats_type          nxt
);

   logic [LAT_W:0] avg_sum;

   // The average sum carries one extra bit so the add cannot overflow before the halving.
   assign avg_sum = {1'b0, cur.avg_latency} + {1'b0, latency};

   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_SENT: begin
            nxt.sent_packets = cur.sent_packets + CNT_W'(1);
            nxt.sent_bytes   = cur.sent_bytes + BCNT_W'(pkt_bytes);
         end
         CMD_RECV: begin
            nxt.recv_packets = cur.recv_packets + CNT_W'(1);
            nxt.recv_bytes   = cur.recv_bytes + BCNT_W'(pkt_bytes);
            if (latency > cur.max_latency) begin
               nxt.max_latency = latency;
            end
            if (latency < cur.min_latency) begin
               nxt.min_latency = latency;
            end
            nxt.avg_latency = avg_sum[LAT_W:1];
         end
         CMD_SEQ_ERR: begin
            nxt.seq_errors = cur.seq_errors + CNT_W'(1);
         end
         CMD_TS_ERR: begin
            nxt.ts_errors = cur.ts_errors + CNT_W'(1);
         end
         CMD_CLEAR: begin
            nxt = STATS_RESET;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== sv/stream_packet_latency_stats_unit.sv =====
// Top level of the stream packet latency statistics block.
//
// The req channel carries one event per beat: a command (packet sent,
// packet received, sequence error, timestamp error or clear), a packet
// size and a latency. The rsp channel returns one beat per event with a
// snapshot of all counters and latency marks as they stand after it.
// Unused command codes leave the statistics unchanged but still answer.
//
// An event is captured in an input register, then combinational adds and
// compares update the statistics registers, which drive the rsp fields
// directly. A response passes the input register and then the statistics
// registers, and the block sustains one event per cycle while rsp_stall is low.
//
// Reset clears both pipeline registers and returns every counter to zero
// and the minimum latency to all ones. When the receiver stalls, the
// statistics hold, the input register keeps one pending event, and
// req_stall rises once that register is full and cannot drain.
module stream_packet_latency_stats_unit
   import splat_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [BYTES_W-1:0] req_pkt_bytes,
   input  logic [LAT_W-1:0]   req_latency,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CNT_W-1:0]   rsp_sent_packets_out,
   output logic [CNT_W-1:0]   rsp_recv_packets_out,
   output logic [BCNT_W-1:0]  rsp_sent_bytes_out,
   output logic [BCNT_W-1:0]  rsp_recv_bytes_out,
   output logic [CNT_W-1:0]   rsp_seq_errors_out,
   output logic [CNT_W-1:0]   rsp_ts_errors_out,
   output logic [LAT_W-1:0]   rsp_max_latency_out,
   output logic [LAT_W-1:0]   rsp_min_latency_out,
   output logic [LAT_W-1:0]   rsp_avg_latency_out
);

   logic               in_valid_ff;
   cmd_type            in_cmd_ff;
   logic [BYTES_W-1:0] in_bytes_ff;
   logic [LAT_W-1:0]   in_latency_ff;

   logic               out_valid_ff;
   stats_type          stats_ff;
   stats_type          stats_in;

   logic               out_free;
   logic               advance;
   logic               req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff     <= cmd_type'(req_cmd);
         in_bytes_ff   <= req_pkt_bytes;
         in_latency_ff <= req_latency;
      end
   end

   splat_update u_update (
      .cur       (stats_ff),
      .cmd       (in_cmd_ff),
      .pkt_bytes (in_bytes_ff),
      .latency   (in_latency_ff),
      .nxt       (stats_in)
   );

   // The statistics only move when a response slot is free, so they also
   // serve as the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         stats_ff     <= STATS_RESET;
      end else begin
         if (advance) begin
            stats_ff <= stats_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_sent_packets_out = stats_ff.sent_packets;
   assign rsp_recv_packets_out = stats_ff.recv_packets;
   assign rsp_sent_bytes_out   = stats_ff.sent_bytes;
   assign rsp_recv_bytes_out   = stats_ff.recv_bytes;
   assign rsp_seq_errors_out   = stats_ff.seq_errors;
   assign rsp_ts_errors_out    = stats_ff.ts_errors;
   assign rsp_max_latency_out  = stats_ff.max_latency;
   assign rsp_min_latency_out  = stats_ff.min_latency;
   assign rsp_avg_latency_out  = stats_ff.avg_latency;

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("event advanced without a response");

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      (advance && in_cmd_ff == CMD_CLEAR) |=> (stats_ff == STATS_RESET))
      else $error("clear did not restore reset values");

   a_marks_ordered: assert property (@(posedge clock) disable iff (reset)
      (stats_ff.max_latency >= stats_ff.min_latency) ||
      (stats_ff.min_latency == '1 && stats_ff.max_latency == '0))
      else $error("latency marks out of order");

endmodule
